@@ src/read_quality_filter_unit_assert.svh @@
// ----------------------------------------------------------------------------
// read_quality_filter_unit_assert.svh
// Assertion macros shared by the read quality filter files. Each macro expects
// signals named clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef READ_QUALITY_FILTER_UNIT_ASSERT_SVH
`define READ_QUALITY_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RQF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("read quality filter: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RQF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("read quality filter: next-cycle check failed");

`endif

@@ src/rqf_pkg.sv @@
// ----------------------------------------------------------------------------
// rqf_pkg
// Shared types and constants of the read quality filter.
// ----------------------------------------------------------------------------
package rqf_pkg;

    localparam int unsigned QUAL_W      = 8;
    localparam int unsigned CODE_W      = 8;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    // Register map of the configuration channel
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_QUALITY_THRESHOLD = 3'd0,
        REG_RUN_LIMIT         = 3'd1,
        REG_PASS_CODE         = 3'd2,
        REG_REJECT_CODE       = 3'd3,
        REG_BIOLOGICAL_MASK   = 3'd4
    } cfg_index_t;

    localparam logic [QUAL_W-1:0] RST_QUALITY_THRESHOLD = 8'd20;
    localparam logic [7:0]        RST_RUN_LIMIT         = 8'd10;
    localparam logic [CODE_W-1:0] RST_PASS_CODE         = 8'd0;
    localparam logic [CODE_W-1:0] RST_REJECT_CODE       = 8'd1;
    localparam logic [7:0]        RST_BIOLOGICAL_MASK   = 8'd1;

    typedef struct packed {
        logic [QUAL_W-1:0] quality_threshold;
        logic [7:0]        run_limit;
        logic [CODE_W-1:0] pass_code;
        logic [CODE_W-1:0] reject_code;
        logic [7:0]        biological_mask;
    } cfg_t;

endpackage

@@ src/rqf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rqf_cfg_regs
// Configuration register bank; decodes the write channel into five registers.
// ----------------------------------------------------------------------------
module rqf_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rqf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rqf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rqf_pkg::cfg_t                   cfg
);
    import rqf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_QUALITY_THRESHOLD: cfg_next.quality_threshold = cfg_data;
                REG_RUN_LIMIT:         cfg_next.run_limit         = cfg_data;
                REG_PASS_CODE:         cfg_next.pass_code         = cfg_data;
                REG_REJECT_CODE:       cfg_next.reject_code       = cfg_data;
                REG_BIOLOGICAL_MASK:   cfg_next.biological_mask   = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quality_threshold <= RST_QUALITY_THRESHOLD;
            cfg_reg.run_limit         <= RST_RUN_LIMIT;
            cfg_reg.pass_code         <= RST_PASS_CODE;
            cfg_reg.reject_code       <= RST_REJECT_CODE;
            cfg_reg.biological_mask   <= RST_BIOLOGICAL_MASK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/rqf_read_stats.sv @@
// ----------------------------------------------------------------------------
// rqf_read_stats
// Per-read counters: position, low scores, trailing and leading low runs.
// ----------------------------------------------------------------------------
`include "read_quality_filter_unit_assert.svh"

module rqf_read_stats
#(
    parameter int unsigned MAX_READ_LEN = 65535,
    parameter int unsigned CNT_W        = $clog2(MAX_READ_LEN + 1)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,     // non-empty score consumed
    input  logic                       is_last,
    input  logic [rqf_pkg::QUAL_W-1:0] quality,
    input  logic [rqf_pkg::QUAL_W-1:0] threshold,
    output logic [CNT_W-1:0]           pos_upd,     // counts including this score
    output logic [CNT_W-1:0]           low_upd,
    output logic [CNT_W-1:0]           trail_upd,
    output logic [CNT_W-1:0]           lead_upd
);
    import rqf_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_READ_LEN);

    logic [CNT_W-1:0] pos_reg,   pos_next;
    logic [CNT_W-1:0] low_reg,   low_next;
    logic [CNT_W-1:0] trail_reg, trail_next;
    logic [CNT_W-1:0] lead_reg,  lead_next;
    logic             good_reg,  good_next;
    logic             is_low;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v >= MAX_CNT) ? MAX_CNT : v + CNT_W'(1);
    endfunction

    assign is_low = (quality < threshold);

    always_comb
    begin
        pos_upd   = sat_inc(pos_reg);
        low_upd   = is_low ? sat_inc(low_reg) : low_reg;
        trail_upd = is_low ? sat_inc(trail_reg) : '0;
        lead_upd  = (is_low && !good_reg) ? sat_inc(lead_reg) : lead_reg;

        pos_next   = pos_reg;
        low_next   = low_reg;
        trail_next = trail_reg;
        lead_next  = lead_reg;
        good_next  = good_reg;
        if (advance)
        begin
            if (is_last)
            begin
                // read finished: start the next one from zero
                pos_next   = '0;
                low_next   = '0;
                trail_next = '0;
                lead_next  = '0;
                good_next  = 1'b0;
            end
            else
            begin
                pos_next   = pos_upd;
                low_next   = low_upd;
                trail_next = trail_upd;
                lead_next  = lead_upd;
                good_next  = good_reg | ~is_low;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            low_reg   <= '0;
            trail_reg <= '0;
            lead_reg  <= '0;
            good_reg  <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            low_reg   <= low_next;
            trail_reg <= trail_next;
            lead_reg  <= lead_next;
            good_reg  <= good_next;
        end
    end

    `RQF_ASSERT_IMPL(a_low_within_pos, 1'b1, low_reg <= pos_reg)
    `RQF_ASSERT_IMPL(a_trail_within_low, 1'b1, trail_reg <= low_reg)
    `RQF_ASSERT_IMPL(a_lead_within_low, 1'b1, lead_reg <= low_reg)
    `RQF_ASSERT_NEXT(a_last_clears, advance && is_last, pos_reg == '0 && !good_reg)

endmodule

@@ src/rqf_verdict.sv @@
// ----------------------------------------------------------------------------
// rqf_verdict
// Applies the rejection rules to a finished read and picks the filter code.
// ----------------------------------------------------------------------------
module rqf_verdict
#(
    parameter int unsigned CNT_W = 16
)
(
    input  rqf_pkg::cfg_t              cfg,
    input  logic                       empty_read,
    input  logic [rqf_pkg::CODE_W-1:0] filter_in,
    input  logic [7:0]                 type_bits,
    input  logic [CNT_W-1:0]           pos_cnt,
    input  logic [CNT_W-1:0]           low_cnt,
    input  logic [CNT_W-1:0]           trail_cnt,
    input  logic [CNT_W-1:0]           lead_cnt,
    output logic [rqf_pkg::CODE_W-1:0] filter_out,
    output logic                       quality_rejected
);
    import rqf_pkg::*;

    logic             checked;
    logic             too_many_low;
    logic             long_read;
    logic             run_fail;
    logic [CNT_W-1:0] limit_ext;

    assign limit_ext    = CNT_W'(cfg.run_limit);
    assign checked      = (filter_in == cfg.pass_code) &&
                          ((type_bits & cfg.biological_mask) == cfg.biological_mask);
    // more than half low: 2*low > len
    assign too_many_low = {low_cnt, 1'b0} > {1'b0, pos_cnt};
    assign long_read    = pos_cnt > limit_ext;
    // trailing run + 1 > limit is trailing run >= limit
    assign run_fail     = (trail_cnt >= limit_ext) || (lead_cnt > limit_ext);

    always_comb
    begin
        quality_rejected = !empty_read && checked && (too_many_low || (long_read && run_fail));
        filter_out       = quality_rejected ? cfg.reject_code : filter_in;
    end

endmodule

@@ src/read_quality_filter_unit.sv @@
// A read's last score word waits in the input register until the result register is free.
// Throughput: one score word per cycle with no gap between reads, unless m_tready holds a result.
// Input register, counter update plus rule logic, then the result register set the timing.
// Reset: counters clear, both word registers go empty, and the configuration
// registers return to threshold 20, run limit 10, pass 0, reject 1, mask 1.
// ----------------------------------------------------------------------------
// read_quality_filter_unit
// Streaming quality filter for sequencing reads. Each input word carries one
// quality score; tlast marks the final score of a read and tuser flags an
// empty read. One result word is emitted per finished or empty read.
// ----------------------------------------------------------------------------
`include "read_quality_filter_unit_assert.svh"

module read_quality_filter_unit
#(
    parameter int unsigned MAX_READ_LEN = 65535
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // quality[7:0], filter_in[15:8],
                                                       // type_bits[23:16]
    input  logic                            s_tlast,   // is_last
    input  logic                            s_tuser,   // empty_read

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // filter_out[7:0]
    output logic                            m_tuser,   // quality_rejected

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rqf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rqf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rqf_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_READ_LEN + 1);

    cfg_t cfg;

    // Input register stage
    logic              s1_valid_reg, s1_valid_next;
    logic [QUAL_W-1:0] s1_quality_reg;
    logic              s1_last_reg;
    logic              s1_empty_reg;
    logic [CODE_W-1:0] s1_filter_reg;
    logic [7:0]        s1_type_reg;

    // Result register stage
    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] out_filter_reg;
    logic              out_rej_reg;

    logic              in_accept;
    logic              s1_has_result;
    logic              out_free;
    logic              s1_advance;
    logic              stats_advance;

    logic [CNT_W-1:0]  pos_upd, low_upd, trail_upd, lead_upd;
    logic [CODE_W-1:0] filter_out;
    logic              quality_rejected;

    rqf_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the held word moves on when it makes no result or the result
    // register is free (empty, or being drained this cycle).
    assign s1_has_result = s1_empty_reg || s1_last_reg;
    assign out_free      = !out_valid_reg || m_tready;
    assign s1_advance    = s1_valid_reg && (!s1_has_result || out_free);
    assign s_tready      = !s1_valid_reg || s1_advance;
    assign in_accept     = s_tvalid && s_tready;
    // An empty read leaves the counters of a read in progress alone
    assign stats_advance = s1_advance && !s1_empty_reg;

    rqf_read_stats #(
        .MAX_READ_LEN (MAX_READ_LEN),
        .CNT_W        (CNT_W)
    ) u_stats
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (stats_advance),
        .is_last   (s1_last_reg),
        .quality   (s1_quality_reg),
        .threshold (cfg.quality_threshold),
        .pos_upd   (pos_upd),
        .low_upd   (low_upd),
        .trail_upd (trail_upd),
        .lead_upd  (lead_upd)
    );

    rqf_verdict #(
        .CNT_W (CNT_W)
    ) u_verdict
    (
        .cfg              (cfg),
        .empty_read       (s1_empty_reg),
        .filter_in        (s1_filter_reg),
        .type_bits        (s1_type_reg),
        .pos_cnt          (pos_upd),
        .low_cnt          (low_upd),
        .trail_cnt        (trail_upd),
        .lead_cnt         (lead_upd),
        .filter_out       (filter_out),
        .quality_rejected (quality_rejected)
    );

    always_comb
    begin
        // hold the input word until it moves on; a new word may replace it at once
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;

        // load a result, drop it once taken, otherwise hold
        out_valid_next = out_valid_reg;
        if (s1_advance && s1_has_result)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_quality_reg <= s_tdata[7:0];
            s1_filter_reg  <= s_tdata[15:8];
            s1_type_reg    <= s_tdata[23:16];
            s1_last_reg    <= s_tlast;
            s1_empty_reg   <= s_tuser;
        end
        if (s1_advance && s1_has_result)
        begin
            out_filter_reg <= filter_out;
            out_rej_reg    <= quality_rejected;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_filter_reg;
    assign m_tuser  = out_rej_reg;

    `RQF_ASSERT_IMPL(a_ready_when_empty, !s1_valid_reg, s_tready)
    `RQF_ASSERT_NEXT(a_result_loaded, s1_advance && s1_has_result, m_tvalid)
    `RQF_ASSERT_IMPL(a_empty_never_rejected, s1_valid_reg && s1_empty_reg, !quality_rejected)

endmodule
